[sv/idbs_pkg.sv]
// ----------------------------------------------------------------------------
// idbs_pkg: shared types and constants for the integrate-and-dump bit slicer
// Register indexes, the configuration struct with its reset values, and the
// fixed widths of the accumulator, the phase residue and the config fields.
// ----------------------------------------------------------------------------
package idbs_pkg;

  // default sample width, Q15 audio
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // fixed datapath widths
  localparam int unsigned ACC_W      = 25;
  localparam int unsigned RES_W      = 18;
  localparam int unsigned SPB_W      = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned SCALE_W    = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // one sample worth of phase, Q8
  localparam logic [SPB_W-1:0]   SPB_MIN    = 16'd256;
  localparam logic [RES_W-1:0]   ONE_SAMPLE = 18'd256;
  // unity spike scale, Q8
  localparam logic [SCALE_W-1:0] SCALE_MAX  = 9'd256;

  // saturation limits of the bit sum
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // register indexes on the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPB         = 3'd0,
    CFG_MANCHESTER  = 3'd1,
    CFG_INVERT      = 3'd2,
    CFG_SPIKE_EN    = 3'd3,
    CFG_SPIKE_THR   = 3'd4,
    CFG_SPIKE_SCALE = 3'd5
  } cfg_idx_e;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [SPB_W-1:0]   spb_q8;
    logic               manchester;
    logic               invert;
    logic               spike_en;
    logic [THR_W-1:0]   spike_thr;
    logic [SCALE_W-1:0] spike_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    spb_q8:      16'd2560,
    manchester:  1'b0,
    invert:      1'b0,
    spike_en:    1'b0,
    spike_thr:   16'd16384,
    spike_scale: 9'd69
  };

endpackage

[sv/integrate_dump_bit_slicer.sv]
// ----------------------------------------------------------------------------
// integrate_dump_bit_slicer: audio bit slicer, integrate and dump
// Top level: config registers, spike stage and integrator.
// ----------------------------------------------------------------------------
// One sample is accepted per clock while in_stall_o is low. A sample goes
// through two registers: the input stage (inversion, window and spike
// correction, one multiplier) and the integrator (saturating accumulate,
// phase residue, result register), so a bit decided by a sample reaches
// the output through the input stage and the result register, and a
// stalled result holds it in the input stage. With spike suppression on, a
// sample is processed only when the next sample arrives, so each bit comes
// out one input beat later. The accumulator and phase residue update
// together, at one sample per clock unless the result stalls. While a
// result waits on out_stall_i at most one further sample is taken in.
// Config writes take effect the next cycle and should only be issued idle.
module integrate_dump_bit_slicer import idbs_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   restart_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   bit_res_o,
  output logic [ACC_W-1:0]       bit_sum_o
);

  cfg_t                   cfg;
  logic                   take;
  logic                   mid_valid;
  logic [SAMPLE_BITS-1:0] mid_sample;
  logic                   mid_restart;

  // configuration registers
  idbs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input stage
  idbs_spike #(.SAMPLE_BITS(SAMPLE_BITS)) u_spike (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .restart_i  (restart_i),
    .take_i     (take),
    .valid_o    (mid_valid),
    .sample_o   (mid_sample),
    .restart_o  (mid_restart)
  );

  // integrator and result register
  idbs_integ #(.SAMPLE_BITS(SAMPLE_BITS)) u_integ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (mid_valid),
    .sample_i    (mid_sample),
    .restart_i   (mid_restart),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bit_res_o   (bit_res_o),
    .bit_sum_o   (bit_sum_o)
  );

endmodule

[sv/idbs_cfg.sv]
// ----------------------------------------------------------------------------
// idbs_cfg: configuration register file
// Write-only register bank; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module idbs_cfg import idbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode one write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SPB:         cfg_d.spb_q8      = cfg_data_i[SPB_W-1:0];
        CFG_MANCHESTER:  cfg_d.manchester  = cfg_data_i[0];
        CFG_INVERT:      cfg_d.invert      = cfg_data_i[0];
        CFG_SPIKE_EN:    cfg_d.spike_en    = cfg_data_i[0];
        CFG_SPIKE_THR:   cfg_d.spike_thr   = cfg_data_i[THR_W-1:0];
        CFG_SPIKE_SCALE: cfg_d.spike_scale = cfg_data_i[SCALE_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/idbs_spike.sv]
// ----------------------------------------------------------------------------
// idbs_spike: input stage with inversion and spike suppression
// Registers the input beat, keeps the two-sample window and hands the
// (possibly corrected) sample to the integrator from that register.
// ----------------------------------------------------------------------------
module idbs_spike import idbs_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   restart_i,
  input  logic                   take_i,
  output logic                   valid_o,
  output logic [SAMPLE_BITS-1:0] sample_o,
  output logic                   restart_o
);

  localparam int unsigned NW = SAMPLE_BITS + 1;
  localparam int unsigned DW = SAMPLE_BITS + 3;
  localparam int unsigned CW = (DW > THR_W + 1) ? DW : THR_W + 1;
  localparam int unsigned PW = SAMPLE_BITS + 13;
  localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [PW-1:0]   ROUND_HALF = PW'(256);

  logic                   valid_q, valid_d;
  logic [SAMPLE_BITS-1:0] s_q;
  logic                   restart_q;
  logic [SAMPLE_BITS-1:0] w0_q, w1_q;
  logic                   ready;
  logic                   accept;

  logic [SAMPLE_BITS-1:0] x;
  logic signed [NW-1:0]   nsum;
  logic signed [DW-1:0]   dev;
  logic [DW-1:0]          mag;
  logic                   is_spike;
  logic [SCALE_W-1:0]     scale_eff;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   total;
  logic [SAMPLE_BITS-1:0] s_d;

  // handshake: room when empty or when the integrator takes the held beat
  assign ready      = !valid_q || take_i;
  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;
  assign valid_d    = ready ? in_valid_i : valid_q;

  // optional negation, most negative value clips to the largest positive
  always_comb begin
    x = sample_i;
    if (cfg_i.invert) begin
      x = (sample_i == SMIN) ? SMAX : -sample_i;
    end
  end

  // deviation of the middle sample from its neighbors: d = 2*w0 - (w1 + x)
  assign nsum = $signed({w1_q[SAMPLE_BITS-1], w1_q}) + $signed({x[SAMPLE_BITS-1], x});
  assign dev  = $signed({{2{w0_q[SAMPLE_BITS-1]}}, w0_q, 1'b0})
              - $signed({{2{nsum[NW-1]}}, nsum});
  assign mag  = dev[DW-1] ? DW'(-dev) : DW'(dev);
  assign is_spike = CW'(mag) > CW'({cfg_i.spike_thr, 1'b0});

  // pull toward the mean: floor((nsum*256 + scale*d + 256) / 512)
  assign scale_eff = (cfg_i.spike_scale > SCALE_MAX) ? SCALE_MAX : cfg_i.spike_scale;
  assign prod      = $signed({1'b0, scale_eff}) * dev;
  assign total     = $signed({{4{nsum[NW-1]}}, nsum, 8'd0}) + prod + ROUND_HALF;

  // processed sample: delayed middle sample with suppression on, else current
  always_comb begin
    if (cfg_i.spike_en) begin
      s_d = is_spike ? total[SAMPLE_BITS+8:9] : w0_q;
    end else begin
      s_d = x;
    end
  end

  // control and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      w0_q    <= '0;
      w1_q    <= '0;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        w1_q <= w0_q;
        w0_q <= x;
      end
    end
  end

  // beat payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q       <= s_d;
      restart_q <= restart_i;
    end
  end

  assign valid_o   = valid_q;
  assign sample_o  = s_q;
  assign restart_o = restart_q;

endmodule

[sv/idbs_integ.sv]
// ----------------------------------------------------------------------------
// idbs_integ: integrate-and-dump with fractional bit timing
// Saturating accumulator, Q8 phase residue, Manchester half tracking and the
// result register.
// ----------------------------------------------------------------------------
module idbs_integ import idbs_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   valid_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   restart_i,
  output logic                   take_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   bit_res_o,
  output logic [ACC_W-1:0]       bit_sum_o
);

  localparam int unsigned EW = ACC_W + 1;

  logic [ACC_W-1:0] acc_q;
  logic [RES_W-1:0] res_q;
  logic             half_q;
  logic             out_valid_q, out_valid_d;
  logic             bit_res_q;
  logic [ACC_W-1:0] bit_sum_q;

  logic             advance;
  logic [ACC_W-1:0] acc_b;
  logic [RES_W-1:0] res_b;
  logic             half_b;
  logic [SPB_W-1:0] spb_eff;
  logic [RES_W-1:0] res_add;
  logic [RES_W-1:0] res_n;
  logic             res_end;
  logic             first_half;
  logic             emit;
  logic [EW-1:0]    s_ext;
  logic [EW-1:0]    sum;
  logic [ACC_W-1:0] sum_sat;

  // result register free or draining this cycle
  assign take_o  = !out_valid_q || !out_stall_i;
  assign advance = valid_i && take_o;

  // restart clears timing before this sample
  assign acc_b  = restart_i ? '0 : acc_q;
  assign res_b  = restart_i ? '0 : res_q;
  assign half_b = restart_i ? 1'b0 : half_q;

  // phase residue: reload at period start, one sample off each beat
  assign spb_eff = (cfg_i.spb_q8 < SPB_MIN) ? SPB_MIN : cfg_i.spb_q8;
  assign res_add = (res_b[RES_W-1] || res_b == '0) ? res_b + RES_W'(spb_eff) : res_b;
  assign res_n   = res_add - ONE_SAMPLE;
  assign res_end = res_n[RES_W-1] || res_n == '0;

  assign first_half = cfg_i.manchester && !half_b;
  assign emit       = !first_half && res_end;

  // saturating add or subtract
  assign s_ext = {{(EW-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
  assign sum   = first_half ? {acc_b[ACC_W-1], acc_b} - s_ext
                            : {acc_b[ACC_W-1], acc_b} + s_ext;
  always_comb begin
    if (sum[EW-1] != sum[EW-2]) begin
      sum_sat = sum[EW-1] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  // result valid: drained beat clears, a new bit sets
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end
  end

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      res_q       <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        res_q <= res_n;
        if (first_half) begin
          acc_q  <= sum_sat;
          half_q <= res_end;
        end else if (emit) begin
          acc_q  <= '0;
          half_q <= 1'b0;
        end else begin
          acc_q  <= sum_sat;
          half_q <= half_b;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      bit_res_q <= !sum_sat[ACC_W-1];
      bit_sum_q <= sum_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bit_res_o   = bit_res_q;
  assign bit_sum_o   = bit_sum_q;

endmodule

[sv/idbs_checker.sv]
// ----------------------------------------------------------------------------
// idbs_checker: port-level checks for the bit slicer
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module idbs_checker import idbs_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_we_i,
  input logic [CFG_IDX_W-1:0]   cfg_index_i,
  input logic [CFG_DATA_W-1:0]  cfg_data_i,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [SAMPLE_BITS-1:0] sample_i,
  input logic                   restart_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic                   bit_res_o,
  input logic [ACC_W-1:0]       bit_sum_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bit_sum_o) && $stable(bit_res_o))
    else $error("result beat changed while stalled");

  // decision matches the sign of the sum
  a_bit_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bit_res_o == !bit_sum_o[ACC_W-1])
    else $error("bit decision disagrees with sum sign");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // a fresh result needs an accepted input beat behind the input stage and result registers
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching input beat");

endmodule

bind integrate_dump_bit_slicer idbs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_idbs_checker (.*);
